>>> hdl/lpfd_pkg.sv
// Shared types and codes for the length-prefixed frame decoder.
`timescale 1ns / 1ps

package lpfd_pkg;

  // One input word: a buffer byte and its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } lpfd_in_t;

  // One output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_in_data;
    logic       frame_end;
    logic [1:0] frame_status;
  } lpfd_out_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_LEN   = 2'd2,
    ST_SUM   = 2'd3
  } lpfd_status_e;

  // What the back end does with a queued byte.
  typedef enum logic [1:0] {
    OP_SKIP = 2'd0,  // no hash, no output
    OP_SUM  = 2'd1,  // shift into the expected checksum
    OP_HDR  = 2'd2,  // hash and emit as header
    OP_DATA = 2'd3   // hash and emit as data
  } lpfd_op_e;

  // Classified word passed from front to back.
  typedef struct packed {
    logic [7:0]   data_byte;
    lpfd_op_e     op;
    logic         last;
    lpfd_status_e status;
  } lpfd_cmd_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic not_empty;
  } lpfd_qstat_t;

endpackage

>>> hdl/lpfd_front.sv
// Front end: prelude capture, payload classification and length check.
`timescale 1ns / 1ps

module lpfd_front #(
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lpfd_pkg::lpfd_in_t in_i,
  output logic               push_o,
  output lpfd_pkg::lpfd_cmd_t cmd_o
);
  import lpfd_pkg::*;

  localparam logic [4:0]  PreludeBytes = 5'd24;
  localparam logic [4:0]  PreludeLast  = 5'd23;
  localparam logic [4:0]  HdrEnd       = 5'd8;
  localparam logic [4:0]  BodyEnd      = 5'd16;
  // Largest length sum that still leaves room for the prelude.
  localparam logic [63:0] SumLimit     = 64'hFFFF_FFFF_FFFF_FFE7;

  logic [4:0]            pos_q, pos_d;
  logic [63:0]           hdr_q, hdr_d;
  logic [63:0]           body_q, body_d;
  logic [64:0]           sum_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  in_prelude;
  logic [63:0]           cnt_ext;
  logic                  is_hdr;
  logic                  is_data;
  logic                  len_err;
  lpfd_op_e              op;
  lpfd_status_e          status;

  always_comb begin
    in_prelude = pos_q < PreludeBytes;
    cnt_ext    = 64'(cnt_q);
    is_hdr     = cnt_ext < hdr_q;
    // sum carry out means every count lies below the declared end
    is_data    = !is_hdr && (sum_q[64] || (cnt_ext < sum_q[63:0]));

    pos_d  = pos_q;
    hdr_d  = hdr_q;
    body_d = body_q;
    cnt_d  = cnt_q;
    op     = OP_SKIP;

    if (in_prelude) begin
      if (pos_q < HdrEnd) begin
        hdr_d = {hdr_q[55:0], in_i.in_byte};
      end else if (pos_q < BodyEnd) begin
        body_d = {body_q[55:0], in_i.in_byte};
      end else begin
        op = OP_SUM;
      end
      pos_d = pos_q + 5'd1;
    end else begin
      if (is_hdr) begin
        op = OP_HDR;
      end else if (is_data) begin
        op = OP_DATA;
      end
      if (cnt_q != '1) begin
        cnt_d = cnt_q + COUNT_BITS'(1);
      end
    end

    len_err = sum_q[64] || (sum_q[63:0] > SumLimit) || (cnt_d == '1) ||
              (64'(cnt_d) != sum_q[63:0]);

    if (!in_i.in_last) begin
      status = ST_OK;
    end else if (in_prelude && (pos_q < PreludeLast)) begin
      status = ST_TRUNC;
    end else if (len_err) begin
      status = ST_LEN;
    end else begin
      status = ST_OK;
    end
  end

  assign push_o          = accept_i && ((op != OP_SKIP) || in_i.in_last);
  assign cmd_o.data_byte = in_i.in_byte;
  assign cmd_o.op        = op;
  assign cmd_o.last      = in_i.in_last;
  assign cmd_o.status    = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr_q  <= '0;
      body_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      if (in_i.in_last) begin
        pos_q  <= '0;
        hdr_q  <= '0;
        body_q <= '0;
        cnt_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        hdr_q  <= hdr_d;
        body_q <= body_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Lengths are settled long before the first payload byte; track them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= {1'b0, hdr_q} + {1'b0, body_q};
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PreludeBytes)
    else $error("prelude position past end of prelude");
`endif

endmodule

>>> hdl/lpfd_queue.sv
// Two-word queue between the front and back ends.
`timescale 1ns / 1ps

module lpfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpfd_pkg::lpfd_cmd_t  push_cmd_i,
  input  logic                 pop_i,
  output lpfd_pkg::lpfd_cmd_t  head_o,
  output lpfd_pkg::lpfd_qstat_t stat_o
);
  import lpfd_pkg::*;

  lpfd_cmd_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.full      = cnt_q == 2'd2;
  assign stat_o.not_empty = cnt_q != 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && stat_o.full |-> pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.not_empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> hdl/lpfd_back.sv
// Back end: FNV-1a 64 hash, checksum compare and output register.
`timescale 1ns / 1ps

module lpfd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpfd_pkg::lpfd_cmd_t   head_i,
  input  lpfd_pkg::lpfd_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lpfd_pkg::lpfd_out_t   out_data_o
);
  import lpfd_pkg::*;

  localparam logic [63:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

  logic [63:0]  hash_q, hash_d;
  logic [63:0]  exp_q, exp_d;
  logic         out_valid_q;
  lpfd_out_t    out_q;

  logic [63:0]  mix;
  logic         is_payload;
  logic         produces;
  logic         out_free;
  lpfd_status_e status;
  lpfd_out_t    res;

  always_comb begin
    // prime 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0
    mix = hash_q ^ 64'(head_i.data_byte);
    is_payload = (head_i.op == OP_HDR) || (head_i.op == OP_DATA);
    hash_d = is_payload ? (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) +
                          (mix << 4) + (mix << 1) + mix
                        : hash_q;
    exp_d  = (head_i.op == OP_SUM) ? {exp_q[55:0], head_i.data_byte} : exp_q;

    if (!head_i.last) begin
      status = ST_OK;
    end else if (head_i.status != ST_OK) begin
      status = head_i.status;
    end else if (hash_d != exp_d) begin
      status = ST_SUM;
    end else begin
      status = ST_OK;
    end

    res.out_byte       = is_payload ? head_i.data_byte : 8'd0;
    res.out_byte_valid = is_payload;
    res.out_in_data    = head_i.op == OP_DATA;
    res.frame_end      = head_i.last;
    res.frame_status   = status;
  end

  assign produces    = is_payload || head_i.last;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = qstat_i.not_empty && (out_free || !produces);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
      exp_q  <= '0;
    end else if (pop_o) begin
      if (head_i.last) begin
        hash_q <= FnvBasis;
        exp_q  <= '0;
      end else begin
        hash_q <= hash_d;
        exp_q  <= exp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produces) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_status != ST_OK) |-> out_data_o.frame_end)
    else $error("error status on a word that does not end the frame");
  a_data_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_in_data |-> out_data_o.out_byte_valid)
    else $error("data tag without a payload byte");
`endif

endmodule

>>> hdl/length_prefixed_frame_decoder_top.sv
// Top level of the length-prefixed frame decoder with FNV-1a 64 check.
`timescale 1ns / 1ps

// Decodes a framed buffer presented one byte per input word, in_last marking
// the final byte. The first 24 bytes are a big-endian prelude: header length,
// body length and expected FNV-1a 64 checksum. Each following byte within the
// declared header+body length comes out as one word tagged header or data and
// is hashed; bytes past that length are dropped silently. The word for the
// last byte carries frame_end and the status: ok, truncated prelude, length
// mismatch or checksum mismatch, checked in that order. Drop the payload of a
// frame whose status is an error. The block takes one word per cycle when not
// stalled; it registers each word in the queue, then at the output. The
// rate is set by the hash update in the back end, one shift-add multiply by
// the FNV prime per cycle. A two-word queue separates classification from
// hashing, so input stall rises only when the queue is full. COUNT_BITS sets
// the payload counter width (16 to 64); a saturated count is a length error.
module length_prefixed_frame_decoder_top #(
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpfd_pkg::lpfd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpfd_pkg::lpfd_out_t out_data_o
);
  import lpfd_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  lpfd_cmd_t   push_cmd;
  lpfd_cmd_t   head;
  lpfd_qstat_t qstat;

  // Hold the input off only while the queue cannot take a word.
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  lpfd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  lpfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .stat_o    (qstat)
  );

  lpfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> sim/lpfd_frame_checker.sv
// Channel monitor and predictor for the length-prefixed frame decoder.
`timescale 1ns / 1ps

module lpfd_frame_checker #(
  parameter int unsigned COUNT_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lpfd_pkg::lpfd_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lpfd_pkg::lpfd_out_t out_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         outstanding_o
);

  import lpfd_pkg::*;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] COUNT_MAX   = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam int unsigned PRELUDE_LEN = 24;

  int unsigned prelude_pos;
  logic [63:0] hdr_len;
  logic [63:0] body_bytes;
  logic [63:0] sum_field;
  logic [63:0] payload_cnt;
  logic [63:0] hash_acc;
  lpfd_out_t   predicted_words[$];
  int unsigned n_mismatch = 0;

  assign mismatch_count_o = n_mismatch;

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x * FNV_PRIME;
  endfunction

  task automatic clear_frame();
    prelude_pos = 0;
    hdr_len     = '0;
    body_bytes  = '0;
    sum_field   = '0;
    payload_cnt = '0;
    hash_acc    = FNV_BASIS;
  endtask

  // Advance the frame state by one byte; queue the word it should produce.
  task automatic decode_byte(input lpfd_in_t w);
    lpfd_out_t   res;
    logic [63:0] total;
    logic        wraps;
    res = '0;
    if (prelude_pos < PRELUDE_LEN) begin
      if (prelude_pos < 8)       hdr_len    = {hdr_len[55:0], w.in_byte};
      else if (prelude_pos < 16) body_bytes = {body_bytes[55:0], w.in_byte};
      else                       sum_field  = {sum_field[55:0], w.in_byte};
      prelude_pos++;
    end else begin
      if (payload_cnt < hdr_len) begin
        res.out_byte_valid = 1'b1;
      end else if (payload_cnt - hdr_len < body_bytes) begin
        res.out_byte_valid = 1'b1;
        res.out_in_data    = 1'b1;
      end
      if (res.out_byte_valid) begin
        hash_acc     = fnv_fold(hash_acc, w.in_byte);
        res.out_byte = w.in_byte;
      end
      if (payload_cnt < COUNT_MAX) payload_cnt++;
    end
    if (w.in_last) begin
      res.frame_end = 1'b1;
      if (prelude_pos < PRELUDE_LEN) begin
        res.frame_status = ST_TRUNC;
      end else begin
        total = hdr_len + body_bytes;
        wraps = (total < hdr_len) || (total + 64'd24 < total);
        if (wraps || payload_cnt >= COUNT_MAX || payload_cnt != total)
          res.frame_status = ST_LEN;
        else if (hash_acc != sum_field)
          res.frame_status = ST_SUM;
        else
          res.frame_status = ST_OK;
      end
      clear_frame();
    end
    if (res.out_byte_valid || res.frame_end) predicted_words = {predicted_words, res};
  endtask

  task automatic check_word(input lpfd_out_t got);
    lpfd_out_t exp;
    if (predicted_words.size() == 0) begin
      $error("unexpected output word %0h", got);
      n_mismatch++;
    end else begin
      exp = predicted_words.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
        n_mismatch++;
      end
      if (got.out_byte_valid !== exp.out_byte_valid) begin
        $error("out_byte_valid: expected %0b, got %0b", exp.out_byte_valid,
               got.out_byte_valid);
        n_mismatch++;
      end
      if (got.out_in_data !== exp.out_in_data) begin
        $error("out_in_data: expected %0b, got %0b", exp.out_in_data, got.out_in_data);
        n_mismatch++;
      end
      if (got.frame_end !== exp.frame_end) begin
        $error("frame_end: expected %0b, got %0b", exp.frame_end, got.frame_end);
        n_mismatch++;
      end
      if (got.frame_status !== exp.frame_status) begin
        $error("frame_status: expected %0d, got %0d", exp.frame_status,
               got.frame_status);
        n_mismatch++;
      end
    end
  endtask

  // Compare before predicting: an output never answers an input taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      predicted_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
    end
    outstanding_o = predicted_words.size();
  end

endmodule

>>> sim/length_prefixed_frame_decoder_top_tb.sv
// Testbench top for the length-prefixed frame decoder: stimulus and verdict.
`timescale 1ns / 1ps

module length_prefixed_frame_decoder_top_tb;

  import lpfd_pkg::*;

  localparam int unsigned COUNT_W     = 64;
  localparam int unsigned WORD_TARGET = 2000;
  // Drop all idling once this many words have gone in.
  localparam int unsigned QUIET_FROM  = 1700;
  // Allow several times the worst-case time per word over the whole run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lpfd_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lpfd_out_t   out_word;
  int unsigned mismatches;
  int unsigned outstanding;

  bit          idle_on = 1'b1;
  int unsigned words_sent = 0;
  int unsigned stall_run = 0;
  int unsigned cycle_cnt = 0;
  logic [7:0]  frame_bytes[$];

  always #10 clk_i = ~clk_i;

  length_prefixed_frame_decoder_top #(
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_word)
  );

  lpfd_frame_checker #(
    .COUNT_BITS(COUNT_W)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_word),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_word),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  // Hard stop: a hung handshake or a lost word ends up here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: hold stall for a burst drawn by $urandom_range, then release.
  // Exactly one assignment to out_stall per falling edge.
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (rst_ni && idle_on && $urandom_range(0, 9) == 0) begin
      stall_run = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hash the way the block does it: xor, then multiply by the FNV prime as shift-add.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Present one word at a falling edge and hold it until a rising edge takes it.
  // Optionally drop valid first for a random gap.
  task automatic send_word(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{in_byte: b, in_last: l};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
    if (words_sent >= QUIET_FROM) idle_on = 1'b0;
    @(negedge clk_i);
  endtask

  // Send the assembled buffer, marking its final byte.
  task automatic send_buffer();
    foreach (frame_bytes[i]) send_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic put_u64(input logic [63:0] v);
    for (int i = 7; i >= 0; i--) frame_bytes = {frame_bytes, v[i*8 +: 8]};
  endtask

  // Build and send a prelude plus n_bytes of random payload. With fix_sum the
  // checksum field is the true hash of the declared part, xored with sum_xor;
  // otherwise it is random.
  task automatic send_frame(input logic [63:0] hdr_len, input logic [63:0] body_size,
                            input int unsigned n_bytes, input bit fix_sum,
                            input logic [63:0] sum_xor);
    logic [7:0]  payload[$];
    logic [63:0] h;
    logic [7:0]  b;
    h = FNV_BASIS;
    for (int i = 0; i < n_bytes; i++) begin
      b = 8'($urandom);
      payload = {payload, b};
      if (i < hdr_len + body_size) h = fnv_step(h, b);
    end
    frame_bytes.delete();
    put_u64(hdr_len);
    put_u64(body_size);
    put_u64(fix_sum ? (h ^ sum_xor) : {$urandom, $urandom});
    foreach (payload[i]) frame_bytes = {frame_bytes, payload[i]};
    send_buffer();
  endtask

  // Raw random bytes, last mark on the final one.
  task automatic send_noise(input int unsigned n_bytes);
    frame_bytes.delete();
    repeat (n_bytes) frame_bytes = {frame_bytes, 8'($urandom)};
    send_buffer();
  endtask

  initial begin
    logic [63:0] hl;
    logic [63:0] bl;
    int unsigned kind;
    int unsigned span;
    int unsigned delta;

    // Hold reset, then release it on a falling edge.
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short buffer: the very first byte is already the last one.
    send_word(8'hff, 1'b1);
    // Empty payload: prelude closes the buffer, zero lengths, bare offset basis.
    send_frame(64'd0, 64'd0, 0, 1'b1, 64'd0);

    while (words_sent < WORD_TARGET) begin
      kind = $urandom_range(0, 99);
      hl   = 64'($urandom_range(0, 12));
      bl   = ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom_range(0, 32));
      span = 32'(hl + bl);
      if (kind < 55) begin
        // Well-formed frame, correct checksum.
        send_frame(hl, bl, span, 1'b1, 64'd0);
      end else if (kind < 65) begin
        // Checksum mismatch: flip one bit of the stored sum.
        send_frame(hl, bl, span, 1'b1, 64'd1 << $urandom_range(0, 63));
      end else if (kind < 75) begin
        // Length mismatch: trail excess bytes past the end or cut the payload short.
        delta = $urandom_range(1, 6);
        if (span == 0 || $urandom_range(0, 1) == 0)
          send_frame(hl, bl, span + delta, 1'b1, 64'd0);
        else
          send_frame(hl, bl, (delta > span) ? 0 : span - delta, 1'b1, 64'd0);
      end else if (kind < 79) begin
        // Full-range lengths: exercise every length bit, mostly wrapping sums.
        send_frame({$urandom, $urandom}, {$urandom, $urandom},
                   $urandom_range(0, 8), 1'b0, 64'd0);
      end else if (kind < 83) begin
        // Sum fits 64 bits but adding the prelude size wraps to zero.
        send_frame(64'hffff_ffff_ffff_ffe8 - bl, bl, $urandom_range(0, 8), 1'b1, 64'd0);
      end else if (kind < 91) begin
        // Truncated prelude.
        send_noise($urandom_range(1, 23));
      end else begin
        send_noise($urandom_range(1, 40));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then give the pipeline time to
    // show any stray output.
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/lpfd_pkg.sv
hdl/lpfd_front.sv
hdl/lpfd_queue.sv
hdl/lpfd_back.sv
hdl/length_prefixed_frame_decoder_top.sv
sim/lpfd_frame_checker.sv
sim/length_prefixed_frame_decoder_top_tb.sv
